// ===== design/g6dec_pkg.sv =====
`default_nettype none

package g6dec_pkg;

    localparam int CharW    = 8;
    localparam int VertW    = 12;
    localparam int CountW   = 13;
    localparam int StatusW  = 2;
    localparam int PrefixW  = 4;
    localparam int StepW    = 3;
    localparam int BitsW    = 6;

    localparam logic [CharW-1:0]   CharHeader  = 8'h3E;   // '>'
    localparam logic [CharW-1:0]   CharLow     = 8'd63;
    localparam logic [CharW-1:0]   CharHigh    = 8'd126;
    localparam logic [PrefixW-1:0] HeaderLen   = 4'd10;
    localparam logic [PrefixW-1:0] ShortPrefix = 4'd1;
    localparam logic [PrefixW-1:0] LongPrefix  = 4'd4;
    localparam logic [CountW-1:0]  ShortMaxN   = 13'd62;
    localparam logic [CountW-1:0]  WalkEnd     = 13'd4096;
    localparam logic [StepW-1:0]   LastStep    = 3'd5;

    localparam logic [StatusW-1:0] ST_OK       = 2'd0;
    localparam logic [StatusW-1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [StatusW-1:0] ST_RANGE    = 2'd2;

    localparam int FifoDepth = 2;
    localparam int FifoPtrW  = $clog2(FifoDepth);
    localparam int FifoCntW  = $clog2(FifoDepth + 1);

    // one data byte handed from front to back
    typedef struct packed {
        logic             restart;   // start of a new graph before this byte
        logic             bad;
        logic [BitsW-1:0] bits;
    } entry_t;

endpackage

`default_nettype wire

// ===== design/g6dec_in_if.sv =====
`default_nettype none

interface g6dec_in_if;
    import g6dec_pkg::*;

    logic             valid;
    logic             ready;
    logic [CharW-1:0] char_code;
    logic             start_of_graph;

    modport source (output valid, output char_code, output start_of_graph, input ready);
    modport sink   (input valid, input char_code, input start_of_graph, output ready);
endinterface

`default_nettype wire

// ===== design/g6dec_out_if.sv =====
`default_nettype none

interface g6dec_out_if;
    import g6dec_pkg::*;

    logic               valid;
    logic               ready;
    logic [VertW-1:0]   vertex_high;
    logic [VertW-1:0]   vertex_low;
    logic [StatusW-1:0] status;
    logic               last_of_byte;

    modport source (output valid, output vertex_high, output vertex_low, output status,
                    output last_of_byte, input ready);
    modport sink   (input valid, input vertex_high, input vertex_low, input status,
                    input last_of_byte, output ready);
endinterface

`default_nettype wire

// ===== design/g6dec_fifo.sv =====
`default_nettype none

module g6dec_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire g6dec_pkg::entry_t push_data,
    input  wire logic             pop,
    output g6dec_pkg::entry_t     head,
    output logic                  full,
    output logic                  empty
);
    import g6dec_pkg::*;

    entry_t                mem_reg [FifoDepth];
    logic [FifoPtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FifoPtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FifoCntW-1:0]   count_reg, count_next;

    assign full  = (count_reg == FifoCntW'(FifoDepth));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/g6dec_front.sv =====
`default_nettype none

module g6dec_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    g6dec_in_if.sink                           chars,
    input  wire logic [g6dec_pkg::CountW-1:0]  num_vertices,
    input  wire logic                          full,
    output logic                               push,
    output g6dec_pkg::entry_t                  push_data
);
    import g6dec_pkg::*;

    logic [PrefixW-1:0] prefix_left_reg, prefix_left_next;
    logic               restart_reg, restart_next;
    logic               accept;
    logic               bad;
    logic [PrefixW-1:0] hdr_len;
    logic [PrefixW-1:0] cnt_len;
    logic [CharW-1:0]   diff;

    assign chars.ready = !full;
    assign accept      = chars.valid && chars.ready;

    assign bad     = (chars.char_code < CharLow) || (chars.char_code > CharHigh);
    assign diff    = chars.char_code - CharLow;
    assign hdr_len = (chars.char_code == CharHeader) ? HeaderLen : '0;
    assign cnt_len = (num_vertices <= ShortMaxN) ? ShortPrefix : LongPrefix;

    always_comb
    begin
        prefix_left_next = prefix_left_reg;
        restart_next     = restart_reg;
        push             = 1'b0;
        push_data.restart = restart_reg;
        push_data.bad     = bad;
        push_data.bits    = bad ? '0 : diff[BitsW-1:0];
        if (accept)
        begin
            if (chars.start_of_graph)
            begin
                // first byte decides header presence; rest of prefix is skipped
                prefix_left_next = hdr_len + cnt_len - 4'd1;
                restart_next     = 1'b1;
            end
            else if (prefix_left_reg != '0)
            begin
                prefix_left_next = prefix_left_reg - 4'd1;
            end
            else
            begin
                push         = 1'b1;
                restart_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_left_reg <= '0;
            restart_reg     <= 1'b0;
        end
        else
        begin
            prefix_left_reg <= prefix_left_next;
            restart_reg     <= restart_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/g6dec_back.sv =====
`default_nettype none

module g6dec_back #(
    parameter int MAX_VERTICES = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [g6dec_pkg::CountW-1:0]  num_vertices,
    input  wire g6dec_pkg::entry_t             head,
    input  wire logic                          empty,
    output logic                               pop,
    g6dec_out_if.source                        edges
);
    import g6dec_pkg::*;

    logic [StepW-1:0]   step_reg, step_next;
    logic [CountW-1:0]  col_reg, col_next;
    logic [VertW-1:0]   row_reg, row_next;
    logic               out_valid_reg, out_valid_next;
    logic [VertW-1:0]   out_high_reg;
    logic [VertW-1:0]   out_low_reg;
    logic [StatusW-1:0] out_status_reg;
    logic               out_last_reg;

    logic               restart_now;
    logic [CountW-1:0]  col_cur, col_s;
    logic [VertW-1:0]   row_cur, row_s;
    logic               advance, frozen;
    logic               bit_set, bad_now, emit, go;
    logic [BitsW-1:0]   rest;
    logic               over;
    logic [VertW-1:0]   res_high, res_low;
    logic [StatusW-1:0] res_status;
    logic               res_last;

    assign restart_now = head.restart && (step_reg == '0);
    assign col_cur     = restart_now ? CountW'(1) : col_reg;
    assign row_cur     = restart_now ? '0 : row_reg;

    // row index reaches the column vertex exactly when the column is done
    assign advance = (col_cur < WalkEnd) && ({1'b0, row_cur} >= col_cur);
    assign col_s   = advance ? col_cur + 1'b1 : col_cur;
    assign row_s   = advance ? '0 : row_cur;
    assign frozen  = (col_s >= WalkEnd);

    assign bit_set = head.bits[LastStep - step_reg];
    assign bad_now = head.bad && (step_reg == LastStep);
    assign rest    = head.bits << (step_reg + 3'd1);
    assign over    = (col_s >= num_vertices) || (int'(col_s) >= MAX_VERTICES);

    assign emit = !empty && (bit_set || bad_now);
    assign go   = !empty && (!emit || !out_valid_reg || edges.ready);
    assign pop  = go && (step_reg == LastStep);

    always_comb
    begin
        if (bad_now)
        begin
            res_high   = '0;
            res_low    = '0;
            res_status = ST_BAD_CHAR;
            res_last   = 1'b1;
        end
        else if (frozen)
        begin
            res_high   = '0;
            res_low    = '0;
            res_status = ST_RANGE;
            res_last   = (rest == '0);
        end
        else
        begin
            res_high   = col_s[VertW-1:0];
            res_low    = row_s;
            res_status = over ? ST_RANGE : ST_OK;
            res_last   = (rest == '0);
        end
    end

    always_comb
    begin
        step_next      = step_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = edges.ready ? 1'b0 : out_valid_reg;
        if (go)
        begin
            step_next = (step_reg == LastStep) ? '0 : step_reg + 3'd1;
            col_next  = col_s;
            row_next  = frozen ? row_s : row_s + 1'b1;
            if (emit)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            col_reg       <= CountW'(1);
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && emit)
        begin
            out_high_reg   <= res_high;
            out_low_reg    <= res_low;
            out_status_reg <= res_status;
            out_last_reg   <= res_last;
        end
    end

    assign edges.valid        = out_valid_reg;
    assign edges.vertex_high  = out_high_reg;
    assign edges.vertex_low   = out_low_reg;
    assign edges.status       = out_status_reg;
    assign edges.last_of_byte = out_last_reg;

endmodule

`default_nettype wire

// ===== design/graph6_edge_decoder.sv =====
// graph6 edge decoder.
// chars: one byte of a graph6 string per word; start_of_graph marks the first
//   byte. That byte and the rest of the header/vertex-count prefix are taken
//   one per cycle while the queue is not full and give no words on edges.
// edges: one word per set adjacency bit (vertex_high, vertex_low, status),
//   last_of_byte on the final word of a byte; a byte outside 63..126 gives a
//   single status word at the end of its slot.
// cfg_we/cfg_wdata: writes num_vertices (reset 1); write only while idle.
// Each data byte runs six walk steps in the back end, one per cycle while the
//   byte is in the queue and no stall on edges holds the walk; a 2-entry queue
//   of data bytes sits between front end and walk. Edge output is registered.
// A stall on edges freezes the walk only at a step that produces a word; the
//   front end keeps taking bytes until the queue fills.
// Reset clears the prefix counter, queue and walk (column 1, row 0).
`default_nettype none

module graph6_edge_decoder #(
    parameter int MAX_VERTICES = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [g6dec_pkg::CountW-1:0]  cfg_wdata,
    g6dec_in_if.sink                           chars,
    g6dec_out_if.source                        edges
);
    import g6dec_pkg::*;

    logic [CountW-1:0] num_vertices_reg;
    logic              push, pop, full, empty;
    entry_t            push_data;
    entry_t            head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vertices_reg <= CountW'(1);
        end
        else if (cfg_we)
        begin
            num_vertices_reg <= cfg_wdata;
        end
    end

    g6dec_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .chars        (chars),
        .num_vertices (num_vertices_reg),
        .full         (full),
        .push         (push),
        .push_data    (push_data)
    );

    g6dec_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    g6dec_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .num_vertices (num_vertices_reg),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .edges        (edges)
    );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import g6dec_pkg::*;

    localparam int MaxVertices = 4096;
    localparam int DrainCycles = 30;

    typedef struct {
        logic [VertW-1:0]   vertex_high;
        logic [VertW-1:0]   vertex_low;
        logic [StatusW-1:0] status;
        logic               last_of_byte;
    } edge_word_t;

    // Decoder model plus the queue of edge words it still owes.
    class graph6_edge_model;
        edge_word_t        expected_edges[$];
        logic [CountW-1:0] vcount;
        logic [PrefixW-1:0] skip_left;
        bit                first_pending;
        int unsigned       tri_pos;
        int unsigned       col;
        int unsigned       col_start;
        int                failures;

        function new();
            vcount = 1;
            skip_left = 0;
            first_pending = 0;
            tri_pos = 0;
            col = 1;
            col_start = 0;
            failures = 0;
        endfunction

        function void take_char(input logic [CharW-1:0] code, input logic first);
            edge_word_t  fresh[$];
            edge_word_t  w;
            int unsigned skip;
            int unsigned limit;
            int unsigned bits;
            bit          bad;
            bit          frozen;
            if (first)
            begin
                tri_pos = 0;
                col = 1;
                col_start = 0;
                first_pending = 1;
            end
            if (first_pending)
            begin
                skip = (code == CharHeader) ? int'(HeaderLen) : 0;
                skip += (vcount <= ShortMaxN) ? int'(ShortPrefix) : int'(LongPrefix);
                skip_left = PrefixW'(skip - 1);
                first_pending = 0;
                return;
            end
            if (skip_left != 0)
            begin
                skip_left--;
                return;
            end
            limit = (vcount > MaxVertices) ? MaxVertices : int'(vcount);
            bad = (code < CharLow) || (code > CharHigh);
            bits = bad ? 0 : int'(code - CharLow);
            for (int k = 0; k < BitsW; k++)
            begin
                if (col < WalkEnd && tri_pos - col_start >= col)
                begin
                    col_start += col;
                    col++;
                end
                frozen = col >= WalkEnd;
                if (((bits >> (5 - k)) & 1) != 0)
                begin
                    w.last_of_byte = 1'b0;
                    if (frozen)
                    begin
                        w.vertex_high = '0;
                        w.vertex_low = '0;
                        w.status = ST_RANGE;
                    end
                    else
                    begin
                        w.vertex_high = VertW'(col);
                        w.vertex_low = VertW'(tri_pos - col_start);
                        w.status = (col >= limit) ? ST_RANGE : ST_OK;
                    end
                    fresh.push_back(w);
                end
                if (!frozen)
                    tri_pos = (tri_pos + 1) & 32'h00FF_FFFF;
            end
            if (bad)
            begin
                w.vertex_high = '0;
                w.vertex_low = '0;
                w.status = ST_BAD_CHAR;
                w.last_of_byte = 1'b0;
                fresh.push_back(w);
            end
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last_of_byte = 1'b1;
            foreach (fresh[i])
                expected_edges.push_back(fresh[i]);
        endfunction

        function void report(input string field, input logic [VertW-1:0] want,
                             input logic [VertW-1:0] got);
            failures++;
            if (failures <= 100)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
        endfunction

        function void match_edge(input edge_word_t got);
            edge_word_t want;
            if (expected_edges.size() == 0)
            begin
                failures++;
                if (failures <= 100)
                    $display("%0t: unexpected word, expected none, actual %0d/%0d/%0d/%0d",
                             $time, got.vertex_high, got.vertex_low, got.status,
                             got.last_of_byte);
                return;
            end
            want = expected_edges.pop_front();
            if (got.vertex_high !== want.vertex_high)
                report("vertex_high", want.vertex_high, got.vertex_high);
            if (got.vertex_low !== want.vertex_low)
                report("vertex_low", want.vertex_low, got.vertex_low);
            if (got.status !== want.status)
                report("status", VertW'(want.status), VertW'(got.status));
            if (got.last_of_byte !== want.last_of_byte)
                report("last_of_byte", VertW'(want.last_of_byte), VertW'(got.last_of_byte));
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CountW-1:0] cfg_wdata;

    g6dec_in_if  chars_bus();
    g6dec_out_if edge_bus();

    graph6_edge_model model = new();

    int burst_left = 0;
    bit hold_req = 0;

    graph6_edge_decoder #(
        .MAX_VERTICES (MaxVertices)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .chars     (chars_bus),
        .edges     (edge_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver: checks accepted words, stalls in modes, one long hold on request.
    initial
    begin
        edge_word_t got;
        int mode;
        int mode_left;
        int hold;
        int cyc;
        mode = 0;
        mode_left = 0;
        hold = 0;
        cyc = 0;
        edge_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (edge_bus.valid && edge_bus.ready)
            begin
                got.vertex_high = edge_bus.vertex_high;
                got.vertex_low = edge_bus.vertex_low;
                got.status = edge_bus.status;
                got.last_of_byte = edge_bus.last_of_byte;
                model.match_edge(got);
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (hold_req)
            begin
                hold = $urandom_range(150, 220);
                hold_req = 0;
            end
            if (hold > 0)
            begin
                hold--;
                edge_bus.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: edge_bus.ready <= 1'b1;
                    1: edge_bus.ready <= 1'($urandom_range(0, 1));
                    2: edge_bus.ready <= (cyc % 4) == 0;
                    default: edge_bus.ready <= $urandom_range(0, 7) == 0;
                endcase
            end
        end
    end

    task automatic send_char(input logic [CharW-1:0] code, input logic first);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
        end
        burst_left--;
        if (gap > 0)
        begin
            chars_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_bus.valid <= 1'b1;
        chars_bus.char_code <= code;
        chars_bus.start_of_graph <= first;
        do
            @(posedge clk);
        while (!chars_bus.ready);
        model.take_char(code, first);
    endtask

    // Skipped bytes give no words, so let the pipe settle after the queue empties.
    task automatic drain();
        while (model.expected_edges.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_count(input logic [CountW-1:0] value);
        chars_bus.valid <= 1'b0;
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        model.vcount = value;
    endtask

    initial
    begin
        logic [CountW-1:0] counts[10];
        int  data_sent;
        int  skip;
        int  len;
        bit  with_header;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        chars_bus.valid = 1'b0;
        chars_bus.char_code = '0;
        chars_bus.start_of_graph = 1'b0;
        counts = '{13'd0, 13'd1, 13'd2, 13'd5, 13'd62, 13'd63, 13'd4096, 13'd8191,
                   13'd0, 13'd0};
        counts[8] = CountW'($urandom_range(1, 4096));
        counts[9] = CountW'($urandom_range(0, 8191));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no start flag seen yet: decode as data, count still 1
        send_char(8'd126, 1'b0);
        send_char(8'd63, 1'b0);
        send_char(8'd0, 1'b0);

        // five vertices, one-byte prefix, bad bytes on both sides of the range
        write_count(13'd5);
        send_char(8'd68, 1'b1);
        send_char(8'd126, 1'b0);
        send_char(8'd255, 1'b0);
        send_char(8'd63, 1'b0);
        send_char(8'd62, 1'b0);
        send_char(8'd64, 1'b0);

        // header text ahead of a short prefix
        write_count(13'd62);
        send_char(CharHeader, 1'b1);
        repeat (10) send_char(8'($urandom_range(0, 255)), 1'b0);
        send_char(8'd126, 1'b0);

        // four-byte prefix
        write_count(13'd63);
        send_char(8'd126, 1'b1);
        repeat (3) send_char(8'($urandom_range(0, 255)), 1'b0);
        send_char(8'd127, 1'b0);

        for (int p = 0; p < 10; p++)
        begin
            write_count(counts[p]);
            if (p == 3 || p == 7)
                hold_req = 1;
            data_sent = 0;
            while (data_sent < 8)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                    data_sent++;
                end
                else
                begin
                    with_header = $urandom_range(0, 3) == 0;
                    send_char(with_header ? CharHeader : 8'($urandom_range(63, 126)), 1'b1);
                    skip = (with_header ? 10 : 0) + ((counts[p] <= ShortMaxN) ? 1 : 4) - 1;
                    repeat (skip) send_char(8'($urandom_range(0, 255)), 1'b0);
                    len = $urandom_range(1, 8);
                    repeat (len)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_char(8'($urandom_range(0, 255)), 1'b0);
                        else
                            send_char(8'($urandom_range(63, 126)), 1'b0);
                        data_sent++;
                    end
                end
            end
        end

        chars_bus.valid <= 1'b0;
        drain();
        if (model.expected_edges.size() != 0)
            model.failures++;
        if (model.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
design/g6dec_pkg.sv
design/g6dec_in_if.sv
design/g6dec_out_if.sv
design/g6dec_fifo.sv
design/g6dec_front.sv
design/g6dec_back.sv
design/graph6_edge_decoder.sv
test/testbench.sv
